### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BST_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/bst_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Types, codes and sizing constants shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int POS_BITS   = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_INT  = 3'd1,
    MODE_NAME = 3'd2,
    MODE_STR  = 3'd3,
    MODE_HALT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_TOKEN    = 3'd0,
    ST_UNCLOSED = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_NOTOKENS = 3'd3,
    ST_TOOLONG  = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    K_OPEN  = 3'd0,
    K_CLOSE = 3'd1,
    K_SEP   = 3'd2,
    K_STR   = 3'd3,
    K_INT   = 3'd4,
    K_NAME  = 3'd5
  } kind_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } res_t;

  // Results produced by one byte, oldest first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Mask or extend an offset to the 16-bit result field.
  function automatic logic [15:0] to_field(logic [POS_BITS-1:0] v);
    logic [POS_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

endpackage

### rtl/core/byte_stream_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Scans text one byte a cycle while in_stall is low, and reports tokens as offset and length.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | text_byte
//   out     | output    | out_valid / out_stall| status, token_kind, start,
//           |           |                      | length, last_of_run
//
// Flow: a byte is taken in every cycle with in_valid high and in_stall low; its
//   results appear in the next cycle at the earliest, from a four-entry result queue.
// A byte yields up to two results, two when it both flushes a pending integer
//   or name and gives its own; the output side, at one result a cycle while
//   out_stall is low, then limits how fast bytes can be taken.
// Reset: synchronous, active low; clears scan state and empties the queue.
// Stalls: in_stall rises when fewer than two queue slots are free, so a byte
//   is only ever taken when all of its results have room.
//
module byte_stream_tokenizer_unit import bst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  push_t push;
  res_t  head;
  logic  space_lo;
  logic  in_acc;

  // A transfer on the input side happens when in_valid is high and the queue has room for two.
  assign in_stall = space_lo;
  assign in_acc   = in_valid && !in_stall;

  // Advance scan state and build this byte's results.
  bst_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .text_byte (in_text_byte),
    .push      (push)
  );

  // Hold results until the downstream side takes each transfer.
  bst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_lo  (space_lo),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  assign out_status       = head.status;
  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule

### rtl/core/bst_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Scan state and the per-byte decision logic; yields up to two results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_scan import bst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] text_byte,
  output push_t      push
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  mode_t                mode_r, mode_nxt;
  logic [POS_BITS-1:0]  start_r, start_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic                 saw_r, saw_nxt;

  logic  flush_en, tail_en;
  res_t  flush_res, tail_res;
  logic  is_digit, is_letter, pending;
  kind_t pend_kind;

  function automatic res_t mk_token(kind_t k, logic [POS_BITS-1:0] s,
                                    logic [POS_BITS-1:0] len);
    res_t r;
    r.status = ST_TOKEN;
    r.kind   = k;
    r.start  = to_field(s);
    r.length = to_field(len);
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(status_t st, logic [POS_BITS-1:0] s);
    res_t r;
    r.status = st;
    r.kind   = K_OPEN;
    r.start  = to_field(s);
    r.length = 16'd0;
    r.last   = 1'b0;
    return r;
  endfunction

  assign is_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_letter = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                     ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
  assign pending   = (mode_r == MODE_INT) || (mode_r == MODE_NAME);
  assign pend_kind = (mode_r == MODE_INT) ? K_INT : K_NAME;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      pos_r   <= '0;
      saw_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      saw_r   <= saw_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    saw_nxt   = saw_r;
    flush_en  = 1'b0;
    tail_en   = 1'b0;
    flush_res = mk_token(pend_kind, start_r, pos_r - start_r);
    tail_res  = mk_status(ST_DONE, '0);
    if (acc) begin
      if (text_byte == CH_NUL) begin
        if (mode_r != MODE_HALT) begin
          flush_en = pending;
          tail_en  = 1'b1;
          if (mode_r == MODE_STR) begin
            tail_res = mk_status(ST_UNCLOSED, start_r);
          end else if (!saw_r && !pending) begin
            tail_res = mk_status(ST_NOTOKENS, '0);
          end
        end
        mode_nxt  = MODE_IDLE;
        start_nxt = '0;
        pos_nxt   = '0;
        saw_nxt   = 1'b0;
      end else if (mode_r == MODE_HALT) begin
        // drop bytes until the end byte
      end else if (pos_r == POS_MAX) begin
        tail_en  = 1'b1;
        tail_res = mk_status(ST_TOOLONG, pos_r);
        mode_nxt = MODE_HALT;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (mode_r == MODE_STR) begin
          if (text_byte == CH_QUOTE) begin
            tail_en  = 1'b1;
            tail_res = mk_token(K_STR, start_r, pos_r - start_r);
            saw_nxt  = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end else if (!((mode_r == MODE_INT) && is_digit) &&
                     !((mode_r == MODE_NAME) && (is_letter || text_byte == CH_UNDER))) begin
          flush_en = pending;
          if (pending) begin
            saw_nxt = 1'b1;
          end
          mode_nxt = MODE_IDLE;
          if (text_byte == CH_LPAREN || text_byte == CH_LBRACK ||
              text_byte == CH_LBRACE) begin
            tail_en  = 1'b1;
            tail_res = mk_token(K_OPEN, pos_r, POS_BITS'(1));
            saw_nxt  = 1'b1;
          end else if (text_byte == CH_RPAREN || text_byte == CH_RBRACK ||
                       text_byte == CH_RBRACE) begin
            tail_en  = 1'b1;
            tail_res = mk_token(K_CLOSE, pos_r, POS_BITS'(1));
            saw_nxt  = 1'b1;
          end else if (text_byte == CH_SEMI) begin
            tail_en  = 1'b1;
            tail_res = mk_token(K_SEP, pos_r, POS_BITS'(1));
            saw_nxt  = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            mode_nxt  = MODE_STR;
            start_nxt = pos_r + 1'b1;
          end else if (is_digit) begin
            mode_nxt  = MODE_INT;
            start_nxt = pos_r;
          end else if (is_letter) begin
            mode_nxt  = MODE_NAME;
            start_nxt = pos_r;
          end else begin
            tail_en  = 1'b1;
            tail_res = mk_status(ST_BADCHAR, pos_r);
            mode_nxt = MODE_HALT;
          end
        end
      end
    end
  end

  // Pack oldest first; mark the final result of the byte.
  always_comb begin
    push.cnt     = {1'b0, flush_en} + {1'b0, tail_en};
    push.r0      = flush_en ? flush_res : tail_res;
    push.r0.last = !(flush_en && tail_en);
    push.r1      = tail_res;
    push.r1.last = 1'b1;
  end

  `BST_ASSERT_IMP(a_halt_silent, acc && mode_r == MODE_HALT && text_byte != CH_NUL, push.cnt == 2'd0, "halted scanner produced a result")
  `BST_ASSERT_IMP(a_end_reports, acc && text_byte == CH_NUL && mode_r != MODE_HALT, push.cnt != 2'd0, "end byte gave no final status")

endmodule

### rtl/core/bst_fifo.sv
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small register queue; takes up to two results a cycle, gives one while out_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_fifo import bst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space_lo,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Hold the producer off unless two slots are free.
  assign space_lo  = (count_r > CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  `BST_ASSERT(a_count_bound, count_r <= CNT_W'(FIFO_DEPTH), "queue count above depth")
  `BST_ASSERT_IMP(a_no_overflow, push.cnt != 2'd0, ({1'b0, count_r} + (CNT_W+1)'(push.cnt)) <= (CNT_W+1)'(FIFO_DEPTH), "queue written past capacity")
  `BST_ASSERT(a_ptr_track, PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r), "queue pointers disagree with count")

endmodule
